/* rtl/tsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text screen paginator package
// Shared types, field widths, character codes and defaults.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned TEXT_BYTE_W   = 8;
  localparam int unsigned PAGE_INDEX_W  = 24;
  localparam int unsigned BYTE_OFFSET_W = 32;
  localparam int unsigned PAGE_WIDTH_W  = 16;
  localparam int unsigned SCREEN_LINES_W = 8;

  localparam int unsigned DEF_OFFSET_BITS = 32;
  localparam int unsigned DEF_COLUMN_BITS = 16;
  localparam int unsigned DEF_PAGE_BITS   = 24;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic REG_SCREEN_LINES = 1'b0;

  localparam logic [SCREEN_LINES_W-1:0] SCREEN_LINES_RESET = 8'd24;
  localparam logic [SCREEN_LINES_W-1:0] FIRST_TEXT_ROW     = 8'd2;

  localparam int unsigned TAB_STEP  = 8;
  localparam int unsigned TAB_SHIFT = $clog2(TAB_STEP);

  localparam logic [TEXT_BYTE_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [TEXT_BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [TEXT_BYTE_W-1:0] CHAR_FORM_FEED = 8'h0C;

  localparam int unsigned RESULT_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_PHYS    = 2'd0,
    KIND_SCREEN  = 2'd1,
    KIND_SUMMARY = 2'd2
  } record_kind_e;

  typedef struct packed {
    record_kind_e               record_kind;
    logic [PAGE_INDEX_W-1:0]    page_index;
    logic [BYTE_OFFSET_W-1:0]   byte_offset;
    logic [PAGE_WIDTH_W-1:0]    page_width;
    logic                       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* rtl/tsp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text byte channel
// Valid/ready channel that carries one file byte or the end marker.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  logic                               valid;
  logic                               ready;
  logic [tsp_pkg::TEXT_BYTE_W-1:0]    text_byte;
  logic                               end_of_file;

  modport source (output valid, output text_byte, output end_of_file, input ready);
  modport sink   (input valid, input text_byte, input end_of_file, output ready);
endinterface

/* rtl/tsp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page record channel
// Valid/ready channel that carries one page start or summary record.
// ----------------------------------------------------------------------------
interface tsp_out_if;
  logic                               valid;
  logic                               ready;
  tsp_pkg::record_kind_e              record_kind;
  logic [tsp_pkg::PAGE_INDEX_W-1:0]   page_index;
  logic [tsp_pkg::BYTE_OFFSET_W-1:0]  byte_offset;
  logic [tsp_pkg::PAGE_WIDTH_W-1:0]   page_width;
  logic                               last_of_run;

  modport source (output valid, output record_kind, output page_index, output byte_offset,
                  output page_width, output last_of_run, input ready);
  modport sink   (input valid, input record_kind, input page_index, input byte_offset,
                  input page_width, input last_of_run, output ready);
endinterface

/* rtl/tsp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paginator core
// Input register, counter state and the per-byte update that builds records.
// ----------------------------------------------------------------------------
module tsp_core #(
  parameter int unsigned OFFSET_BITS = tsp_pkg::DEF_OFFSET_BITS,
  parameter int unsigned COLUMN_BITS = tsp_pkg::DEF_COLUMN_BITS,
  parameter int unsigned PAGE_BITS   = tsp_pkg::DEF_PAGE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  tsp_in_if.sink                                text_i,
  input  logic [tsp_pkg::SCREEN_LINES_W-1:0]    screen_lines_i,
  input  logic                                  space_ok_i,
  output tsp_pkg::push_t                        push_o
);
  import tsp_pkg::*;

  logic                       in_valid_q;
  logic [TEXT_BYTE_W-1:0]     in_byte_q;
  logic                       in_eof_q;
  logic                       fire;

  logic [COLUMN_BITS-1:0]     column_q, column_d;
  logic [SCREEN_LINES_W-1:0]  row_q, row_d;
  logic [PAGE_BITS-1:0]       screen_page_q, screen_page_d;
  logic [PAGE_BITS-1:0]       phys_next_q, phys_next_d;
  logic [COLUMN_BITS-1:0]     max_width_q, max_width_d;
  logic [OFFSET_BITS-1:0]     byte_count_q, byte_count_d;
  logic [OFFSET_BITS-1:0]     last_phys_q, last_phys_d;

  logic [OFFSET_BITS-1:0]     count_inc;
  logic [PAGE_BITS-1:0]       phys_inc;
  logic [PAGE_BITS-1:0]       page_inc;
  logic [COLUMN_BITS:0]       tab_sum;
  logic [COLUMN_BITS-1:0]     tab_column;
  logic [COLUMN_BITS-1:0]     column_inc;
  logic [SCREEN_LINES_W:0]    row_inc;
  logic                       is_tab;
  logic                       is_newline;
  logic                       is_form_feed;
  logic                       screen_break;
  logic                       has_phys;
  logic                       has_second;
  result_t                    phys_rec;
  result_t                    second_rec;

  assign fire = in_valid_q && space_ok_i;
  assign text_i.ready = !in_valid_q || space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      in_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      in_byte_q <= text_i.text_byte;
      in_eof_q  <= text_i.end_of_file;
    end
  end

  assign count_inc  = (byte_count_q == '1) ? byte_count_q : byte_count_q + 1'b1;
  assign phys_inc   = (phys_next_q == '1) ? phys_next_q : phys_next_q + 1'b1;
  assign page_inc   = (screen_page_q == '1) ? screen_page_q : screen_page_q + 1'b1;
  assign column_inc = (column_q == '1) ? column_q : column_q + 1'b1;
  assign tab_sum    = {1'b0, column_q} + (COLUMN_BITS + 1)'(TAB_STEP);
  assign tab_column = tab_sum[COLUMN_BITS] ? '1
                    : {tab_sum[COLUMN_BITS-1:TAB_SHIFT], TAB_SHIFT'(0)};
  assign row_inc    = {1'b0, row_q} + (SCREEN_LINES_W + 1)'(1);

  assign is_tab       = (in_byte_q == CHAR_TAB);
  assign is_newline   = (in_byte_q == CHAR_NEWLINE);
  assign is_form_feed = (in_byte_q == CHAR_FORM_FEED);

  always_comb begin
    column_d      = column_q;
    row_d         = row_q;
    screen_page_d = screen_page_q;
    phys_next_d   = phys_next_q;
    max_width_d   = max_width_q;
    byte_count_d  = byte_count_q;
    last_phys_d   = last_phys_q;
    screen_break  = 1'b0;
    has_phys      = 1'b0;
    has_second    = 1'b0;

    phys_rec.record_kind   = KIND_PHYS;
    phys_rec.page_index    = PAGE_INDEX_W'(phys_next_q);
    phys_rec.byte_offset   = BYTE_OFFSET_W'(byte_count_q);
    phys_rec.page_width    = PAGE_WIDTH_W'(max_width_q);
    phys_rec.last_of_run   = 1'b0;
    second_rec.record_kind = KIND_SUMMARY;
    second_rec.page_index  = PAGE_INDEX_W'(screen_page_q);
    second_rec.byte_offset = BYTE_OFFSET_W'(byte_count_q);
    second_rec.page_width  = PAGE_WIDTH_W'(max_width_q);
    second_rec.last_of_run = 1'b1;

    if (fire) begin
      if (in_eof_q) begin
        has_second = 1'b1;
        if (byte_count_q > last_phys_q) begin
          has_phys    = 1'b1;
          phys_next_d = phys_inc;
          last_phys_d = byte_count_q;
        end
      end else begin
        byte_count_d = count_inc;
        if (is_tab) begin
          column_d = tab_column;
        end else if (is_newline || is_form_feed) begin
          if (column_q > max_width_q) begin
            max_width_d = column_q;
          end
          column_d     = '0;
          screen_break = is_form_feed || (row_inc >= {1'b0, screen_lines_i});
          row_d        = screen_break ? FIRST_TEXT_ROW : row_inc[SCREEN_LINES_W-1:0];
          if (screen_break) begin
            screen_page_d = page_inc;
          end
          if (is_form_feed) begin
            has_phys    = 1'b1;
            phys_next_d = phys_inc;
            last_phys_d = count_inc;
          end
          has_second = screen_break;

          phys_rec.byte_offset   = BYTE_OFFSET_W'(count_inc);
          phys_rec.page_width    = PAGE_WIDTH_W'(max_width_d);
          phys_rec.last_of_run   = !screen_break;
          second_rec.record_kind = KIND_SCREEN;
          second_rec.page_index  = PAGE_INDEX_W'(screen_page_d);
          second_rec.byte_offset = BYTE_OFFSET_W'(count_inc);
          second_rec.page_width  = PAGE_WIDTH_W'(max_width_d);
        end else begin
          column_d = column_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      row_q         <= FIRST_TEXT_ROW;
      screen_page_q <= '0;
      phys_next_q   <= PAGE_BITS'(1);
      max_width_q   <= '0;
      byte_count_q  <= '0;
      last_phys_q   <= '0;
    end else begin
      column_q      <= column_d;
      row_q         <= row_d;
      screen_page_q <= screen_page_d;
      phys_next_q   <= phys_next_d;
      max_width_q   <= max_width_d;
      byte_count_q  <= byte_count_d;
      last_phys_q   <= last_phys_d;
    end
  end

  assign push_o.count  = {has_phys && has_second, has_phys ^ has_second};
  assign push_o.first  = has_phys ? phys_rec : second_rec;
  assign push_o.second = second_rec;

endmodule

/* rtl/tsp_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paginator result queue
// Small register queue that takes up to two records a cycle and sends one.
// ----------------------------------------------------------------------------
module tsp_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsp_pkg::push_t   push_i,
  output logic             space_ok_o,
  tsp_out_if.source        record_o
);
  import tsp_pkg::*;

  localparam int unsigned PTR_W = $clog2(RESULT_DEPTH);
  localparam int unsigned CNT_W = $clog2(RESULT_DEPTH + 1);

  result_t            entries_q [RESULT_DEPTH];
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;
  result_t            head;

  assign head       = entries_q[rd_ptr_q];
  assign pop        = record_o.valid && record_o.ready;
  assign space_ok_o = (count_q - CNT_W'(pop)) <= CNT_W'(RESULT_DEPTH - 2);

  assign record_o.valid       = (count_q != '0);
  assign record_o.record_kind = head.record_kind;
  assign record_o.page_index  = head.page_index;
  assign record_o.byte_offset = head.byte_offset;
  assign record_o.page_width  = head.page_width;
  assign record_o.last_of_run = head.last_of_run;

  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
  assign count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_ptr_q + PTR_W'(1)] <= push_i.second;
    end
  end

endmodule

/* rtl/text_screen_paginator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text screen paginator
// Splits a byte stream into screen pages and physical pages and reports each
// page start, then a summary at end of file.
// ----------------------------------------------------------------------------
//  Port      Role    Handshake           Carries
//  text_i    sink    valid/ready         text_byte, end_of_file
//  record_o  source  valid/ready         record_kind, page_index, byte_offset,
//                                        page_width, last_of_run
//  APB       slave   psel/penable/pready screen_lines at byte address 0
//
//  A request is taken into the input register and processed from there.
//  A request yields zero, one or two records; one request per cycle is taken
//  while the four-entry record queue has room for two more records.
//  Requests with two records (form feed, end of file after new data) can hold
//  the input when the output drains one record per cycle.
//  Reset initialises all counters and sets screen_lines to 24; no clearing pass.
// ----------------------------------------------------------------------------
module text_screen_paginator #(
  parameter int unsigned OFFSET_BITS = tsp_pkg::DEF_OFFSET_BITS,
  parameter int unsigned COLUMN_BITS = tsp_pkg::DEF_COLUMN_BITS,
  parameter int unsigned PAGE_BITS   = tsp_pkg::DEF_PAGE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tsp_in_if.sink                            text_i,
  tsp_out_if.source                         record_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tsp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tsp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import tsp_pkg::*;

  logic [SCREEN_LINES_W-1:0]  screen_lines_q;
  logic                       reg_hit;
  logic                       space_ok;
  push_t                      push;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1] == REG_SCREEN_LINES);
  assign prdata  = reg_hit ? APB_DATA_W'(screen_lines_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_lines_q <= SCREEN_LINES_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      screen_lines_q <= pwdata[SCREEN_LINES_W-1:0];
    end
  end

  tsp_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_i         (text_i),
    .screen_lines_i (screen_lines_q),
    .space_ok_i     (space_ok),
    .push_o         (push)
  );

  tsp_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .record_o   (record_o)
  );

endmodule

/* rtl/tsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paginator port checker
// Watches the record channel for handshake and last-of-run flag rules.
// ----------------------------------------------------------------------------
module tsp_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [1:0]                          out_kind,
  input  logic [tsp_pkg::BYTE_OFFSET_W-1:0]   out_offset,
  input  logic                                out_last
);
  import tsp_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("Record valid dropped before it was taken.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_offset) && $stable(out_kind))
    else $error("Stalled record changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_SUMMARY |-> out_last)
    else $error("Summary record is not the last of its run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_PHYS |-> !out_last)
    else $error("Physical page start closed a run.");

endmodule

bind text_screen_paginator tsp_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (record_o.valid),
  .out_ready  (record_o.ready),
  .out_kind   (record_o.record_kind),
  .out_offset (record_o.byte_offset),
  .out_last   (record_o.last_of_run)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text screen paginator testbench
// Streams text bytes and end markers into the paginator with random spacing
// on both channels. A scoreboard tracks column, row, page counters and byte
// count, predicts every page record, and compares each record field by field.
// The screen height register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import tsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_ITEMS  = 1350;
  localparam int unsigned LONG_STALL    = 64;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAB_RUN       = 200;
  localparam int unsigned CW            = DEF_COLUMN_BITS;
  localparam logic [APB_ADDR_W-1:0] ADDR_SCREEN_LINES =
    APB_ADDR_W'(4 * int'(REG_SCREEN_LINES));

  class page_tracker;
    logic [SCREEN_LINES_W-1:0] screen_lines;
    logic [CW-1:0]             column;
    logic [SCREEN_LINES_W-1:0] screen_row;
    logic [PAGE_INDEX_W-1:0]   screen_page;
    logic [PAGE_INDEX_W-1:0]   phys_next;
    logic [PAGE_WIDTH_W-1:0]   max_width;
    logic [BYTE_OFFSET_W-1:0]  byte_count;
    logic [BYTE_OFFSET_W-1:0]  last_phys;
    result_t                   pending_records[$];
    int                        errors;

    function new();
      screen_lines = SCREEN_LINES_RESET;
      column       = '0;
      screen_row   = FIRST_TEXT_ROW;
      screen_page  = '0;
      phys_next    = PAGE_INDEX_W'(1);
      max_width    = '0;
      byte_count   = '0;
      last_phys    = '0;
      errors       = 0;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 50) begin
        $display("ERROR at %0t: %s", $time, what);
      end
    endfunction

    function void set_lines(logic [SCREEN_LINES_W-1:0] value);
      screen_lines = value;
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    function void add_record(record_kind_e kind, logic [PAGE_INDEX_W-1:0] idx,
                             logic [BYTE_OFFSET_W-1:0] offset, logic last);
      result_t rec;
      rec.record_kind = kind;
      rec.page_index  = idx;
      rec.byte_offset = offset;
      rec.page_width  = max_width;
      rec.last_of_run = last;
      pending_records.push_back(rec);
    endfunction

    function void predict_records(logic [TEXT_BYTE_W-1:0] text_byte, logic end_of_file);
      logic [CW:0]             tab_col;
      logic [PAGE_INDEX_W-1:0] phys_idx;
      logic                    ff;
      logic                    brk;
      if (end_of_file) begin
        if (byte_count > last_phys) begin
          add_record(KIND_PHYS, phys_next, byte_count, 1'b0);
          if (phys_next != '1) phys_next = phys_next + 1'b1;
          last_phys = byte_count;
        end
        add_record(KIND_SUMMARY, screen_page, byte_count, 1'b1);
      end else begin
        if (byte_count != '1) byte_count = byte_count + 1'b1;
        if (text_byte == CHAR_TAB) begin
          tab_col = {1'b0, column} + (CW + 1)'(TAB_STEP);
          tab_col = tab_col & ~((CW + 1)'(TAB_STEP - 1));
          column  = tab_col[CW] ? '1 : tab_col[CW-1:0];
        end else if (text_byte == CHAR_NEWLINE || text_byte == CHAR_FORM_FEED) begin
          ff = (text_byte == CHAR_FORM_FEED);
          phys_idx = phys_next;
          if (ff) begin
            if (phys_next != '1) phys_next = phys_next + 1'b1;
            last_phys = byte_count;
          end
          if (PAGE_WIDTH_W'(column) > max_width) max_width = PAGE_WIDTH_W'(column);
          column = '0;
          screen_row = screen_row + 1'b1;
          brk = ff || (screen_row >= screen_lines);
          if (brk) begin
            screen_row = FIRST_TEXT_ROW;
            if (screen_page != '1) screen_page = screen_page + 1'b1;
          end
          if (ff) add_record(KIND_PHYS, phys_idx, byte_count, !brk);
          if (brk) add_record(KIND_SCREEN, screen_page, byte_count, 1'b1);
        end else begin
          if (column != '1) column = column + 1'b1;
        end
      end
    endfunction

    function void check_record(result_t got);
      result_t want;
      if (pending_records.size() == 0) begin
        report($sformatf("unexpected record kind %0d index %0d offset %0d",
                         got.record_kind, got.page_index, got.byte_offset));
      end else begin
        want = pending_records.pop_front();
        if (got.record_kind !== want.record_kind)
          report($sformatf("record_kind got %0d want %0d", got.record_kind, want.record_kind));
        if (got.page_index !== want.page_index)
          report($sformatf("page_index got %0d want %0d", got.page_index, want.page_index));
        if (got.byte_offset !== want.byte_offset)
          report($sformatf("byte_offset got %0d want %0d", got.byte_offset, want.byte_offset));
        if (got.page_width !== want.page_width)
          report($sformatf("page_width got %0d want %0d", got.page_width, want.page_width));
        if (got.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run got %0d want %0d", got.last_of_run, want.last_of_run));
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tsp_in_if  text_if ();
  tsp_out_if rec_if ();

  page_tracker tracker;
  bit          long_stall_req;
  bit          send_steady;
  bit          rec_steady;
  int unsigned items_sent;
  int unsigned cycle_count;

  text_screen_paginator u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .record_o (rec_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic apb_access(input logic write, input logic [SCREEN_LINES_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_SCREEN_LINES;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (!write && prdata[SCREEN_LINES_W-1:0] !== value) begin
      tracker.report($sformatf("screen_lines read %0d want %0d",
                               prdata[SCREEN_LINES_W-1:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_lines(input logic [SCREEN_LINES_W-1:0] value);
    apb_access(1'b1, value);
    tracker.set_lines(value);
    apb_access(1'b0, value);
  endtask

  task automatic send_item(input logic [TEXT_BYTE_W-1:0] text_byte, input logic end_of_file);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= text_byte;
    text_if.end_of_file <= end_of_file;
    do @(posedge clk_i); while (text_if.ready !== 1'b1);
    tracker.predict_records(text_byte, end_of_file);
    items_sent++;
  endtask

  task automatic send_random_item(input int nl_weight);
    int                     pick;
    logic [TEXT_BYTE_W-1:0] text_byte;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_item(TEXT_BYTE_W'($urandom_range(0, 255)), 1'b1);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < nl_weight) text_byte = CHAR_NEWLINE;
      else if (pick < nl_weight + 2) text_byte = CHAR_FORM_FEED;
      else if (pick < nl_weight + 10) text_byte = CHAR_TAB;
      else if (pick < 95) text_byte = TEXT_BYTE_W'($urandom_range(32, 126));
      else text_byte = TEXT_BYTE_W'($urandom_range(0, 255));
      send_item(text_byte, 1'b0);
    end
  endtask

  task automatic wait_idle();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : record_sink
    int      stall;
    result_t got;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_stall_req) begin
        stall = LONG_STALL;
        long_stall_req = 1'b0;
      end else if (rec_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall > 0) begin
        rec_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rec_if.ready <= 1'b1;
      do @(posedge clk_i); while (rec_if.valid !== 1'b1);
      got.record_kind = rec_if.record_kind;
      got.page_index  = rec_if.page_index;
      got.byte_offset = rec_if.byte_offset;
      got.page_width  = rec_if.page_width;
      got.last_of_run = rec_if.last_of_run;
      tracker.check_record(got);
    end
  end

  initial begin : stimulus
    int                        phase;
    int                        phase_items;
    int                        stall_at;
    int                        nl_weight;
    int unsigned               random_start;
    logic [SCREEN_LINES_W-1:0] lines;
    tracker = new();
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    text_if.valid       <= 1'b0;
    text_if.text_byte   <= '0;
    text_if.end_of_file <= 1'b0;
    rec_if.ready        <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_access(1'b0, SCREEN_LINES_RESET);

    // Plain bytes at the extremes, tabs, a newline, back-to-back form feeds,
    // end with and without new data, and codes next to the control bytes.
    send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(CHAR_FORM_FEED, 1'b0);
    send_item(CHAR_FORM_FEED, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h7A, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'h0B, 1'b0);
    send_item(8'h0D, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    wait_idle();
    program_lines(8'd3);
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(8'h71, 1'b0);
    send_item(CHAR_FORM_FEED, 1'b0);
    wait_idle();
    // Screen height below the reserved header rows.
    program_lines(8'd1);
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(8'h00, 1'b1);

    random_start = items_sent;
    phase = 0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 5)
        0: lines = 8'd3;
        1: lines = 8'd255;
        2: lines = SCREEN_LINES_W'($urandom_range(3, 255));
        3: lines = SCREEN_LINES_W'($urandom_range(3, 12));
        default: lines = SCREEN_LINES_RESET;
      endcase
      program_lines(lines);
      send_steady = ($urandom_range(0, 3) == 0);
      rec_steady  = ($urandom_range(0, 3) == 0);
      nl_weight   = (phase == 0) ? 30 : $urandom_range(4, 30);
      phase_items = $urandom_range(100, 250);
      stall_at    = -1;
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        stall_at = $urandom_range(10, phase_items - 20);
      end
      for (int i = 0; i < phase_items; i++) begin
        if (i == stall_at) long_stall_req = 1'b1;
        send_random_item(nl_weight);
      end
      phase++;
    end

    // A long run of tabs builds a very wide line.
    wait_idle();
    program_lines(SCREEN_LINES_W'($urandom_range(3, 255)));
    send_steady = 1'b0;
    rec_steady  = 1'b0;
    for (int i = 0; i < TAB_RUN; i++) send_item(CHAR_TAB, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    for (int i = 0; i < 40; i++) send_random_item(20);
    send_item(8'h00, 1'b1);
    wait_idle();

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
